// File: src/spl_pkg.sv
`timescale 1ns / 1ps

package spl_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int KIND_W = 2;
  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] priority_val;
    logic [TIME_W-1:0] created;
  } rec_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT_FWD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    rec_t     ins;
  } cell_ctl_t;

endpackage

// File: src/spl_cell.sv
`timescale 1ns / 1ps

module spl_cell
  import spl_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      valid,
  input  rec_t      left_rec,
  input  logic      left_le,
  input  rec_t      right_rec,
  output rec_t      rec,
  output logic      le
);

  rec_t rec_r;
  rec_t rec_nxt;

  assign rec = rec_r;
  // entry stays ahead of a new record with the same key
  assign le  = valid && (rec_r.id <= ctl.ins.id);

  always_comb begin
    rec_nxt = rec_r;
    unique case (ctl.op)
      OP_HOLD: begin
        rec_nxt = rec_r;
      end
      OP_INSERT: begin
        if (le) begin
          rec_nxt = rec_r;
        end else if (left_le) begin
          rec_nxt = ctl.ins;
        end else begin
          rec_nxt = left_rec;
        end
      end
      OP_SHIFT_FWD: begin
        rec_nxt = right_rec;
      end
      default: begin
        rec_nxt = rec_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// File: src/sorted_process_list.sv
`timescale 1ns / 1ps

// Sorted process list: up to DEPTH records (id, priority, creation time) kept in
// ascending id order in a row of cells, an insert landing after all equal ids.
// An item is taken whenever start is high; busy never rises, so one item per
// cycle is sustained, since every cell compares and shifts in the same cycle.
// The result for an item appears in the cycle after it is taken, with out_valid
// high for that single cycle; the head fields read zero when the list is empty.
// Insert on a full list or removal on an empty one sets out_rejected and
// leaves the list unchanged. There is no flow control on the result side.

module sorted_process_list
  import spl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [ID_W-1:0]   in_proc_id,
  input  logic [PRIO_W-1:0] in_proc_priority,
  input  logic [TIME_W-1:0] in_created_at,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_head_id,
  output logic [PRIO_W-1:0] out_head_priority,
  output logic [TIME_W-1:0] out_head_created,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic              out_is_full,
  output logic              out_rejected
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rejected_r, rejected_nxt;

  cell_ctl_t ctl;
  rec_t      cell_rec [DEPTH];
  logic      cell_le  [DEPTH];
  logic      cell_valid [DEPTH];

  logic full, empty;

  assign busy  = 1'b0;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.ins.id           = in_proc_id;
    ctl.ins.priority_val = in_proc_priority;
    ctl.ins.created      = in_created_at;
    count_nxt     = count_r;
    rejected_nxt  = rejected_r;
    out_valid_nxt = start;
    if (start) begin
      rejected_nxt = 1'b0;
      unique case (in_kind)
        KIND_INSERT: begin
          if (full) begin
            rejected_nxt = 1'b1;
          end else begin
            ctl.op    = OP_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            rejected_nxt = 1'b1;
          end else begin
            ctl.op    = OP_SHIFT_FWD;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            rejected_nxt = 1'b1;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          rejected_nxt = 1'b0;
        end
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      rec_t left_rec;
      logic left_le;
      rec_t right_rec;

      assign cell_valid[i] = (count_r > CNT_W'(i));

      if (i == 0) begin : g_first
        // front cell takes the new record as soon as it does not keep its own
        assign left_rec = '0;
        assign left_le  = 1'b1;
      end else begin : g_mid
        assign left_rec = cell_rec[i-1];
        assign left_le  = cell_le[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_rec = '0;
      end else begin : g_inner
        assign right_rec = cell_rec[i+1];
      end

      spl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (cell_valid[i]),
        .left_rec  (left_rec),
        .left_le   (left_le),
        .right_rec (right_rec),
        .rec       (cell_rec[i]),
        .le        (cell_le[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rejected_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rejected_r  <= rejected_nxt;
    end
  end

  // head is read from the cells after the update has landed
  assign out_valid         = out_valid_r;
  assign out_head_id       = empty ? '0 : cell_rec[0].id;
  assign out_head_priority = empty ? '0 : cell_rec[0].priority_val;
  assign out_head_created  = empty ? '0 : cell_rec[0].created;
  assign out_entry_count   = count_r;
  assign out_is_full       = full;
  assign out_rejected      = rejected_r;

endmodule

// File: tb/proc_list_checker.sv
`timescale 1ns / 1ps

module proc_list_checker
  import spl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [ID_W-1:0]   in_proc_id,
  input  logic [PRIO_W-1:0] in_proc_priority,
  input  logic [TIME_W-1:0] in_created_at,
  input  logic              out_valid,
  input  logic [ID_W-1:0]   out_head_id,
  input  logic [PRIO_W-1:0] out_head_priority,
  input  logic [TIME_W-1:0] out_head_created,
  input  logic [CNT_W-1:0]  out_entry_count,
  input  logic              out_is_full,
  input  logic              out_rejected,
  output int                mismatches,
  output int                pending
);

  typedef struct {
    rec_t             head;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             rejected;
  } list_status_t;

  rec_t         model_recs [DEPTH];
  int unsigned  model_len;
  list_status_t status_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic list_status_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input rec_t rec);
    list_status_t st;
    int unsigned  pos;
    int unsigned  j;
    st.rejected = 1'b0;
    case (kind)
      KIND_INSERT: begin
        if (model_len >= DEPTH) begin
          st.rejected = 1'b1;
        end else begin
          // new record lands after every entry with an equal or smaller id
          pos = 0;
          while (pos < model_len && model_recs[pos].id <= rec.id) pos++;
          for (j = model_len; j > pos; j--) model_recs[j] = model_recs[j-1];
          model_recs[pos] = rec;
          model_len++;
        end
      end
      KIND_POP_FRONT: begin
        if (model_len == 0) begin
          st.rejected = 1'b1;
        end else begin
          for (j = 1; j < model_len; j++) model_recs[j-1] = model_recs[j];
          model_len--;
        end
      end
      KIND_POP_BACK: begin
        if (model_len == 0) st.rejected = 1'b1;
        else model_len--;
      end
      default: ;
    endcase
    st.head  = (model_len > 0) ? model_recs[0] : '0;
    st.count = model_len[CNT_W-1:0];
    st.full  = (model_len == DEPTH);
    return st;
  endfunction

  always @(posedge clk) begin
    list_status_t want;
    rec_t         rec;
    if (!rst_n) begin
      model_len = 0;
      status_q.delete();
    end else begin
      if (start && !busy) begin
        rec.id           = in_proc_id;
        rec.priority_val = in_proc_priority;
        rec.created      = in_created_at;
        status_q.push_back(apply_request(in_kind, rec));
      end
      if (out_valid) begin
        if (status_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = status_q.pop_front();
          if (out_head_id !== want.head.id)
            report_mismatch($sformatf("head_id got %h want %h", out_head_id, want.head.id));
          if (out_head_priority !== want.head.priority_val)
            report_mismatch($sformatf("head_priority got %h want %h",
                                      out_head_priority, want.head.priority_val));
          if (out_head_created !== want.head.created)
            report_mismatch($sformatf("head_created got %h want %h",
                                      out_head_created, want.head.created));
          if (out_entry_count !== want.count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      out_entry_count, want.count));
          if (out_is_full !== want.full)
            report_mismatch($sformatf("is_full got %b want %b", out_is_full, want.full));
          if (out_rejected !== want.rejected)
            report_mismatch($sformatf("rejected got %b want %b",
                                      out_rejected, want.rejected));
        end
      end
    end
    pending = status_q.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import spl_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_ITEMS   = 100;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] in_kind;
  logic [ID_W-1:0]   in_proc_id;
  logic [PRIO_W-1:0] in_proc_priority;
  logic [TIME_W-1:0] in_created_at;
  logic              out_valid;
  logic [ID_W-1:0]   out_head_id;
  logic [PRIO_W-1:0] out_head_priority;
  logic [TIME_W-1:0] out_head_created;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_is_full;
  logic              out_rejected;
  int                mismatches;
  int                pending;
  int                cycle_cnt;

  sorted_process_list dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_proc_id       (in_proc_id),
    .in_proc_priority (in_proc_priority),
    .in_created_at    (in_created_at),
    .out_valid        (out_valid),
    .out_head_id      (out_head_id),
    .out_head_priority(out_head_priority),
    .out_head_created (out_head_created),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_rejected     (out_rejected)
  );

  proc_list_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_proc_id       (in_proc_id),
    .in_proc_priority (in_proc_priority),
    .in_created_at    (in_created_at),
    .out_valid        (out_valid),
    .out_head_id      (out_head_id),
    .out_head_priority(out_head_priority),
    .out_head_created (out_head_created),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_rejected     (out_rejected),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // hold one beat on the input until the block takes it
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] t);
    start            <= 1'b1;
    in_kind          <= kind;
    in_proc_id       <= id;
    in_proc_priority <= prio;
    in_created_at    <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 16);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ID_W'($urandom_range(0, 65535));
    if (r < 85) return ID_W'($urandom_range(0, 7));   // crowd ids so equal keys pile up
    if (r < 92) return '0;
    return '1;
  endfunction

  initial begin
    int                done;
    int                phase_left;
    int                mode;
    int                r;
    logic [KIND_W-1:0] kind;
    cycle_cnt        = 0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_kind          = KIND_INSERT;
    in_proc_id       = '0;
    in_proc_priority = '0;
    in_created_at    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // removals and the spare code on an empty list, then extremes and equal ids
    send_request(KIND_POP_FRONT, 16'h1234, 8'h12, 32'h1);
    send_request(KIND_POP_BACK, 16'h4321, 8'h34, 32'h2);
    send_request(KIND_UNUSED, 16'hffff, 8'hff, 32'hffff_ffff);
    send_request(KIND_INSERT, 16'hffff, 8'hff, 32'hffff_ffff);
    send_request(KIND_INSERT, 16'h0000, 8'h00, 32'h0000_0000);
    send_request(KIND_INSERT, 16'h0000, 8'haa, 32'h5555_5555);
    send_request(KIND_INSERT, 16'h0000, 8'h55, 32'haaaa_aaaa);
    send_request(KIND_UNUSED, 16'h0000, 8'h00, 32'h0);
    send_request(KIND_INSERT, 16'h8000, 8'h80, 32'h8000_0000);
    send_request(KIND_INSERT, 16'h7fff, 8'h7f, 32'h7fff_ffff);
    send_request(KIND_POP_BACK, 16'h0, 8'h0, 32'h0);
    send_request(KIND_POP_FRONT, 16'h0, 8'h0, 32'h0);
    send_request(KIND_POP_FRONT, 16'h0, 8'h0, 32'h0);
    send_request(KIND_POP_BACK, 16'h0, 8'h0, 32'h0);
    send_request(KIND_POP_FRONT, 16'h0, 8'h0, 32'h0);
    send_request(KIND_POP_FRONT, 16'h0, 8'h0, 32'h0);
    send_request(KIND_POP_BACK, 16'h0, 8'h0, 32'h0);

    // random phases that fill, drain or churn the list
    done       = 0;
    phase_left = 0;
    mode       = 0;
    while (done < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        mode       = $urandom_range(0, 2);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        kind = KIND_UNUSED;
      end else if (r < ((mode == 0) ? 84 : (mode == 1) ? 24 : 52)) begin
        kind = KIND_INSERT;
      end else begin
        kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
      end
      if (done < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 5) == 0) idle_burst();
      send_request(kind, pick_id(), PRIO_W'($urandom_range(0, 255)), $urandom());
      if (kind != KIND_UNUSED) done++;
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
